[hdl/ets_pkg.sv]
// Shared types, codes and character helpers for the expression token scanner.
// No dependencies; every other file in hdl/ imports this package.
package ets_pkg;

    localparam int POSITION_BITS = 16;
    localparam int FIELD_BITS    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [FIELD_BITS-1:0]    field_t;

    localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

    // Scan modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_DOT   = 3'd3;
    localparam logic [2:0] MODE_FRAC  = 3'd4;
    localparam logic [2:0] MODE_ERROR = 3'd5;

    // Token kinds
    localparam logic [3:0] TK_NUMBER = 4'd0;
    localparam logic [3:0] TK_IDENT  = 4'd1;
    localparam logic [3:0] TK_LPAREN = 4'd2;
    localparam logic [3:0] TK_RPAREN = 4'd3;
    localparam logic [3:0] TK_LBRACK = 4'd4;
    localparam logic [3:0] TK_RBRACK = 4'd5;
    localparam logic [3:0] TK_COMMA  = 4'd6;
    localparam logic [3:0] TK_PLUS   = 4'd7;
    localparam logic [3:0] TK_MINUS  = 4'd8;
    localparam logic [3:0] TK_STAR   = 4'd9;
    localparam logic [3:0] TK_EQUAL  = 4'd10;
    localparam logic [3:0] TK_SEMI   = 4'd11;
    localparam logic [3:0] TK_EOL    = 4'd12;
    localparam logic [3:0] TK_END    = 4'd13;
    localparam logic [3:0] TK_ERROR  = 4'd14;

    // Input item kinds
    localparam logic ITEM_CHAR = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // Characters
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_SEMI   = 8'h3b;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } src_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        field_t     token_start;
        field_t     token_length;
        logic       last_of_run;
    } tok_item_t;

    // Results of one accepted item, in order, toward the result queue
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    // Zero when the byte is no single-character token
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_LBRACK: k = TK_LBRACK;
            CH_RBRACK: k = TK_RBRACK;
            CH_COMMA:  k = TK_COMMA;
            CH_PLUS:   k = TK_PLUS;
            CH_MINUS:  k = TK_MINUS;
            CH_STAR:   k = TK_STAR;
            CH_EQUAL:  k = TK_EQUAL;
            CH_SEMI:   k = TK_SEMI;
            CH_LF:     k = TK_EOL;
            default:   k = TK_NUMBER;
        endcase
        return k;
    endfunction

    function automatic pos_t span(input pos_t from, input pos_t upto);
        return (upto >= from) ? pos_t'(upto - from) : '0;
    endfunction

    function automatic field_t to_field(input pos_t p);
        return field_t'(p);
    endfunction

endpackage

[hdl/expression_token_scanner_unit.sv]
// Top level of the expression token scanner: scan state plus result queue.
// Depends on ets_pkg, ets_scan and ets_queue.
//
// Usage:
//   src channel (src_valid / src_stall / src_data) carries one item per
//   accepted handshake: a source byte, or an end-of-input marker.
//   tok channel (tok_valid / tok_stall / tok_data) carries token items:
//   kind, start position, length, and last_of_run on the final token
//   caused by one source item. An item may cause zero, one or two tokens.
//   Throughput: one source item per cycle, sustained as long as tokens are
//   drained at one per cycle; an item that causes two tokens puts both in
//   the queue at once, so the four-entry queue absorbs such bursts.
//   Tokens are registered in the queue and come out on tok in order.
//   src_stall rises when fewer than two queue entries are free; it depends
//   only on the queue fill, never on src_valid.
//   Reset clears the scan mode, position and queue; no token is pending.
//   A stalled tok item holds its value until taken.
module expression_token_scanner_unit
    import ets_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_item_t src_data,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok_data
);

    logic  room;
    logic  accept;
    push_t push;

    // Take an item only when two queue entries are free
    assign src_stall = !room;
    assign accept    = src_valid && room;

    // Advance the scan state and produce this item's tokens
    ets_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_data),
        .push   (push)
    );

    // Hold tokens until the receiver takes them
    ets_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

endmodule

[hdl/ets_scan.sv]
// Scan state registers and the per-item mode update.
// Depends on ets_pkg.
module ets_scan
    import ets_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  src_item_t item,
    output push_t     push
);

    logic [2:0] mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       pstart_reg, pstart_next;

    logic [7:0] c;
    pos_t       pos_adv;
    pos_t       dot_pos;
    logic       v0, v1;
    tok_item_t  t0, t1;

    // Idle-mode scan of the current byte
    logic [2:0] idle_mode;
    pos_t       idle_pstart;
    logic       idle_emit;
    logic [3:0] idle_kind;
    logic [3:0] pk;

    assign c       = item.char_code;
    assign pos_adv = (pos_reg != POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;
    assign dot_pos = (pos_reg != '0) ? pos_reg - pos_t'(1) : '0;
    assign pk      = punct_kind(c);

    always_comb
    begin
        idle_mode   = MODE_IDLE;
        idle_pstart = pos_reg;
        idle_emit   = 1'b0;
        idle_kind   = TK_ERROR;
        priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
        begin
            idle_pstart = pstart_reg;
        end
        else if (is_digit(c))
        begin
            idle_mode = MODE_INT;
        end
        else if (is_alpha(c))
        begin
            idle_mode = MODE_IDENT;
        end
        else if (pk != TK_NUMBER)
        begin
            idle_emit = 1'b1;
            idle_kind = pk;
        end
        else
        begin
            idle_emit = 1'b1;
            idle_mode = MODE_ERROR;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        t0 = '{token_kind: TK_NUMBER, token_start: to_field(pstart_reg),
               token_length: to_field(span(pstart_reg, pos_reg)), last_of_run: 1'b0};
        t1 = '{token_kind: idle_kind, token_start: to_field(pos_reg),
               token_length: field_t'(1), last_of_run: 1'b0};

        if (item.kind == ITEM_END)
        begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            t1 = '{token_kind: TK_END, token_start: to_field(pos_reg),
                   token_length: '0, last_of_run: 1'b0};
            unique case (mode_reg)
                MODE_ERROR: ;
                MODE_DOT:
                begin
                    v0 = 1'b1;
                    v1 = 1'b1;
                    t0.token_length = to_field(span(pstart_reg, dot_pos));
                    t1 = '{token_kind: TK_ERROR, token_start: to_field(dot_pos),
                           token_length: field_t'(1), last_of_run: 1'b0};
                end
                MODE_IDENT, MODE_INT, MODE_FRAC:
                begin
                    v0 = 1'b1;
                    v1 = 1'b1;
                    t0.token_kind = (mode_reg == MODE_IDENT) ? TK_IDENT : TK_NUMBER;
                end
                default: v1 = 1'b1;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_ERROR: ;
                MODE_IDENT:
                begin
                    pos_next = pos_adv;
                    if (!(is_alpha(c) || is_digit(c)))
                    begin
                        v0            = 1'b1;
                        t0.token_kind = TK_IDENT;
                        v1            = idle_emit;
                        mode_next     = idle_mode;
                        pstart_next   = idle_pstart;
                    end
                end
                MODE_INT, MODE_FRAC:
                begin
                    pos_next = pos_adv;
                    priority if (is_digit(c))
                    begin
                    end
                    else if (c == CH_DOT && mode_reg == MODE_INT)
                    begin
                        mode_next = MODE_DOT;
                    end
                    else
                    begin
                        v0          = 1'b1;
                        v1          = idle_emit;
                        mode_next   = idle_mode;
                        pstart_next = idle_pstart;
                    end
                end
                MODE_DOT:
                begin
                    if (is_digit(c))
                    begin
                        mode_next = MODE_FRAC;
                        pos_next  = pos_adv;
                    end
                    else
                    begin
                        // dangling dot: number up to the dot, then the dot as error
                        v0 = 1'b1;
                        v1 = 1'b1;
                        t0.token_length = to_field(span(pstart_reg, dot_pos));
                        t1 = '{token_kind: TK_ERROR, token_start: to_field(dot_pos),
                               token_length: field_t'(1), last_of_run: 1'b0};
                        mode_next = MODE_ERROR;
                    end
                end
                default:
                begin
                    pos_next    = pos_adv;
                    v1          = idle_emit;
                    mode_next   = idle_mode;
                    pstart_next = idle_pstart;
                end
            endcase
        end

        // Pack results in order and mark the final one
        push.count  = {1'b0, v0} + {1'b0, v1};
        push.first  = v0 ? t0 : t1;
        push.second = t1;
        push.first.last_of_run  = !(v0 && v1);
        push.second.last_of_run = 1'b1;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
        end
    end

endmodule

[hdl/ets_queue.sv]
// Small result queue: takes up to two tokens per cycle, delivers one unless tok_stall.
// Depends on ets_pkg.
module ets_queue
    import ets_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok_data
);

    tok_item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   head_reg, head_next;
    logic [QPTR_BITS-1:0]   tail_reg, tail_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   pop;
    logic [QPTR_BITS-1:0]   tail_plus1;

    assign room       = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign tok_valid  = count_reg != '0;
    assign tok_data   = entry_reg[head_reg];
    assign pop        = tok_valid && !tok_stall;
    assign tail_plus1 = tail_reg + QPTR_BITS'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + QPTR_BITS'(1) : head_reg;
        tail_next  = tail_reg + QPTR_BITS'(push.count);
        count_next = count_reg + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/ets_checker.sv]
// Port-level checks for the expression token scanner, bound to the top level.
// Depends on ets_pkg and expression_token_scanner_unit.
module ets_checker
    import ets_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_valid,
    input logic      src_stall,
    input src_item_t src_data,
    input logic      tok_valid,
    input logic      tok_stall,
    input tok_item_t tok_data
);

    // Hold a stalled source item unchanged
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("stalled source item changed");

    // Hold a stalled token unchanged
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
        else $error("stalled token changed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_data.token_kind <= TK_ERROR)
        else $error("token kind out of range");

    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == TK_END |->
            tok_data.token_length == '0 && tok_data.last_of_run)
        else $error("END token malformed");

    a_single_char: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind != TK_NUMBER &&
            tok_data.token_kind != TK_IDENT && tok_data.token_kind != TK_END |->
            tok_data.token_length == field_t'(1) && tok_data.last_of_run)
        else $error("single-character token malformed");

endmodule

bind expression_token_scanner_unit ets_checker u_ets_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
);

[tb/sv/tb_expression_token_scanner_unit.sv]
// Self-checking testbench for expression_token_scanner_unit: directed and random
// character streams, with an in-bench token predictor and a result checker.
// Depends on ets_pkg and the RTL of the scanner; nothing else.
module tb_expression_token_scanner_unit;
    import ets_pkg::*;

    // Cycles with no handshake on either channel before the run is given up.
    localparam int STALL_LIMIT      = 4000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 1150;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    src_item_t src_data;
    logic      tok_valid;
    logic      tok_stall;
    tok_item_t tok_data;

    expression_token_scanner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Token predictor: its own copy of the scan state
    // ------------------------------------------------------------------
    logic [2:0] scan_mode_q;
    pos_t       scan_pos;
    pos_t       token_origin;

    tok_item_t  expected_tokens[$];
    tok_item_t  run_tokens[2];
    int         run_count;
    int         live_items;
    int         fault_count;

    // Knobs set by the stimulus: calm source timing, and a hold-off request to the token sink
    bit         src_calm;
    bit         sink_hold_req;

    function automatic bit char_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit char_starts_word(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    // TK_NUMBER doubles as "not a single-character token"
    function automatic logic [3:0] single_char_kind(input logic [7:0] c);
        case (c)
            CH_LPAREN: return TK_LPAREN;
            CH_RPAREN: return TK_RPAREN;
            CH_LBRACK: return TK_LBRACK;
            CH_RBRACK: return TK_RBRACK;
            CH_COMMA:  return TK_COMMA;
            CH_PLUS:   return TK_PLUS;
            CH_MINUS:  return TK_MINUS;
            CH_STAR:   return TK_STAR;
            CH_EQUAL:  return TK_EQUAL;
            CH_SEMI:   return TK_SEMI;
            CH_LF:     return TK_EOL;
            default:   return TK_NUMBER;
        endcase
    endfunction

    function automatic pos_t run_length(input pos_t from, input pos_t upto);
        return (upto >= from) ? pos_t'(upto - from) : '0;
    endfunction

    // Hold the position once it reaches the top index
    function automatic void bump_position();
        if (scan_pos != POS_MAX)
            scan_pos = scan_pos + 1'b1;
    endfunction

    function automatic void stage_token(input logic [3:0] k, input pos_t start,
                                        input pos_t len);
        tok_item_t t;
        t.token_kind   = k;
        t.token_start  = field_t'(start);
        t.token_length = field_t'(len);
        t.last_of_run  = 1'b0;
        run_tokens[run_count] = t;
        run_count++;
    endfunction

    // Number up to a dot with no digit after it, then an error for the dot
    function automatic void flush_dangling_dot();
        pos_t dot_at;
        dot_at = (scan_pos != '0) ? pos_t'(scan_pos - 1'b1) : '0;
        stage_token(TK_NUMBER, token_origin, run_length(token_origin, dot_at));
        stage_token(TK_ERROR, dot_at, pos_t'(1));
        scan_mode_q = MODE_ERROR;
    endfunction

    // Scan one character as if no token were pending
    function automatic void scan_fresh(input logic [7:0] c);
        logic [3:0] k;
        scan_mode_q = MODE_IDLE;
        if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR))
        begin
            bump_position();
            return;
        end
        token_origin = scan_pos;
        if (char_is_digit(c))
        begin
            scan_mode_q = MODE_INT;
            bump_position();
            return;
        end
        if (char_starts_word(c))
        begin
            scan_mode_q = MODE_IDENT;
            bump_position();
            return;
        end
        k = single_char_kind(c);
        if (k != TK_NUMBER)
        begin
            stage_token(k, scan_pos, pos_t'(1));
            bump_position();
            return;
        end
        stage_token(TK_ERROR, scan_pos, pos_t'(1));
        bump_position();
        scan_mode_q = MODE_ERROR;
    endfunction

    function automatic void clear_scan_state();
        scan_mode_q  = MODE_IDLE;
        scan_pos     = '0;
        token_origin = '0;
    endfunction

    // Work out the tokens that one accepted item causes and queue them
    function automatic void predict_tokens(input src_item_t it);
        logic [7:0] c;
        c = it.char_code;
        run_count = 0;
        if ((it.kind == ITEM_END) || (scan_mode_q != MODE_ERROR))
            live_items++;
        if (it.kind == ITEM_END)
        begin
            case (scan_mode_q)
                MODE_ERROR: ;
                MODE_DOT:   flush_dangling_dot();
                MODE_IDENT, MODE_INT, MODE_FRAC:
                begin
                    stage_token((scan_mode_q == MODE_IDENT) ? TK_IDENT : TK_NUMBER,
                                token_origin, run_length(token_origin, scan_pos));
                    stage_token(TK_END, scan_pos, '0);
                end
                default:    stage_token(TK_END, scan_pos, '0);
            endcase
            clear_scan_state();
        end
        else
        begin
            case (scan_mode_q)
                MODE_ERROR: ;
                MODE_IDENT:
                begin
                    if (char_starts_word(c) || char_is_digit(c))
                        bump_position();
                    else
                    begin
                        stage_token(TK_IDENT, token_origin,
                                    run_length(token_origin, scan_pos));
                        scan_fresh(c);
                    end
                end
                MODE_INT, MODE_FRAC:
                begin
                    if (char_is_digit(c))
                        bump_position();
                    else if ((c == CH_DOT) && (scan_mode_q == MODE_INT))
                    begin
                        scan_mode_q = MODE_DOT;
                        bump_position();
                    end
                    else
                    begin
                        stage_token(TK_NUMBER, token_origin,
                                    run_length(token_origin, scan_pos));
                        scan_fresh(c);
                    end
                end
                MODE_DOT:
                begin
                    if (char_is_digit(c))
                    begin
                        scan_mode_q = MODE_FRAC;
                        bump_position();
                    end
                    else
                        flush_dangling_dot();
                end
                default:    scan_fresh(c);
            endcase
        end
        // Mark the final token of this item and queue all of them in order
        for (int i = 0; i < run_count; i++)
        begin
            if (i == run_count - 1)
                run_tokens[i].last_of_run = 1'b1;
            expected_tokens.insert(expected_tokens.size(), run_tokens[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one item after a random gap (none when src_calm); return at the edge that takes it
    task automatic send_item(input logic kind, input logic [7:0] code);
        src_item_t it;
        int        gap;
        it.kind      = kind;
        it.char_code = code;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        predict_tokens(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(ITEM_CHAR, s[i]);
    endtask

    // Drop valid and hold off until every queued token has come out
    task automatic wait_tokens_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_word_start();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LOW_A + 8'(r);
        if (r < 52)
            return CH_UP_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return pick_word_start();
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 10))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACK;
            3:       return CH_RBRACK;
            4:       return CH_COMMA;
            5:       return CH_PLUS;
            6:       return CH_MINUS;
            7:       return CH_STAR;
            8:       return CH_EQUAL;
            9:       return CH_SEMI;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every token kind but the error, skipped blanks, and a number flushed by the end marker
    task automatic test_token_kinds();
        send_text("_a9([1.25]),+-*=;");
        send_item(ITEM_CHAR, CH_LF);
        send_item(ITEM_CHAR, CH_TAB);
        send_item(ITEM_CHAR, CH_CR);
        send_text(" 7");
        send_item(ITEM_END, 8'hff);
    endtask

    // Dangling dots, error bytes at both ends of the range, input ignored
    // after an error, and an end marker on an empty stream
    task automatic test_dot_and_error();
        send_text("3.xq");
        send_item(ITEM_END, 8'h00);
        send_text("4.");
        send_item(ITEM_END, 8'h00);
        send_item(ITEM_CHAR, 8'hff);
        send_item(ITEM_END, 8'h00);
        send_item(ITEM_CHAR, 8'h00);
        send_item(ITEM_END, 8'hff);
        send_item(ITEM_END, 8'h00);
    endtask

    // Stop draining for a long stretch while items keep coming back to back,
    // so the result queue fills and the input stalls
    task automatic test_receiver_hold_off();
        src_calm      = 1'b1;
        sink_hold_req = 1'b1;
        repeat (40)
            send_item(ITEM_CHAR, pick_punct());
        send_text("ab12 9.5");
        send_item(ITEM_END, 8'h00);
        src_calm = 1'b0;
    endtask

    // Pause the sender mid-stream until the scanner has nothing left to say
    task automatic test_sender_drain_pause();
        send_text("x1 = 42");
        wait_tokens_drained();
        send_text(";y=x1*7.0");
        send_item(ITEM_END, 8'h00);
    endtask

    // One stream of mostly well-formed pieces with some noise bytes
    task automatic send_random_stream();
        int pieces;
        int pick;
        int n;
        pieces   = $urandom_range(0, 12);
        src_calm = ($urandom_range(0, 4) == 0);
        for (int p = 0; p < pieces; p++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                send_item(ITEM_CHAR, pick_word_start());
                n = $urandom_range(0, 6);
                repeat (n) send_item(ITEM_CHAR, pick_word_char());
            end
            else if (pick < 52)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(ITEM_CHAR, pick_digit());
                n = $urandom_range(0, 9);
                if (n < 4)
                begin
                    send_item(ITEM_CHAR, CH_DOT);
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(ITEM_CHAR, pick_digit());
                end
                else if (n == 4)
                    send_item(ITEM_CHAR, CH_DOT);
            end
            else if (pick < 78)
                send_item(ITEM_CHAR, pick_punct());
            else if (pick < 92)
            begin
                n = $urandom_range(1, 2);
                repeat (n) send_item(ITEM_CHAR, pick_blank());
            end
            else
                send_item(ITEM_CHAR, 8'($urandom_range(0, 255)));
        end
        // Now and then let a stream run on into the next one
        if ($urandom_range(0, 9) != 0)
            send_item(ITEM_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_streams();
        int stop_at;
        stop_at = live_items + RANDOM_ITEMS;
        while (live_items < stop_at)
            send_random_stream();
        send_item(ITEM_END, 8'($urandom_range(0, 255)));
        src_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, calm stretches and the requested hold-off
    // ------------------------------------------------------------------
    initial
    begin : token_sink
        int stall_cycles;
        int stretch_left;
        bit sink_calm;
        tok_stall    = 1'b1;
        stretch_left = 0;
        sink_calm    = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stretch_left == 0)
            begin
                sink_calm    = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(20, 60);
            end
            stretch_left--;
            stall_cycles = sink_calm ? 0 : $urandom_range(0, 14);
            if (sink_hold_req)
            begin
                stall_cycles  = stall_cycles + SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (stall_cycles > 0)
            begin
                tok_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            tok_stall <= 1'b0;
            @(posedge clk);
            while (!tok_valid)
                @(posedge clk);
        end
    end

    task automatic note_fault(input string what, input tok_item_t want,
                              input tok_item_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s: expected kind %0d start %0d len %0d last %0b",
                     $realtime, what, want.token_kind, want.token_start,
                     want.token_length, want.last_of_run);
            $display("%0t: %s: actual   kind %0d start %0d len %0d last %0b",
                     $realtime, what, got.token_kind, got.token_start,
                     got.token_length, got.last_of_run);
        end
    endtask

    // Compare every taken token with the oldest expectation
    always @(posedge clk)
    begin
        tok_item_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (expected_tokens.size() == 0)
                note_fault("token with nothing expected", '0, tok_data);
            else
            begin
                want = expected_tokens.pop_front();
                if ((tok_data.token_kind !== want.token_kind) ||
                    (tok_data.token_start !== want.token_start) ||
                    (tok_data.token_length !== want.token_length) ||
                    (tok_data.last_of_run !== want.last_of_run))
                    note_fault("token mismatch", want, tok_data);
            end
        end
    end

    // Give up when neither channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** expression_token_scanner_unit: FAILED **");
        $finish;
    end

    initial
    begin : run_tests
        rst_n         = 1'b0;
        src_valid     = 1'b0;
        src_data      = '0;
        src_calm      = 1'b0;
        sink_hold_req = 1'b0;
        live_items    = 0;
        fault_count   = 0;
        run_count     = 0;
        clear_scan_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_token_kinds();
        test_dot_and_error();
        test_receiver_hold_off();
        test_sender_drain_pause();
        test_random_streams();

        // Drain, then leave room for any stray token to show up
        wait_tokens_drained();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("** expression_token_scanner_unit: PASSED **");
        else
            $display("** expression_token_scanner_unit: FAILED **");
        $finish;
    end

endmodule
